>>> rtl/iff_pkg.sv
// shared types and constants of the integer field formatter
// no dependencies; every other file imports this package

package iff_pkg;

  // field widths of the request and character channels
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned WIDTH_W = 6;
  localparam int unsigned CH_W    = 8;

  // conversion kinds, the unused code behaves as none
  localparam logic [KIND_W-1:0] KIND_S16  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_S32  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_U16  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HEXL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_HEXU = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CHAR = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd6;

  // ascii characters
  localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;

  // bcd conversion: ten digits, one binary bit shifted in per step
  localparam int unsigned NDIG   = 10;
  localparam int unsigned BCD_W  = 4 * NDIG;
  localparam int unsigned ITER_W = 5;
  localparam int unsigned TLEN_W = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_ROUTE,
    ST_PAD_A,
    ST_SIGN,
    ST_PAD_B,
    ST_TEXT,
    ST_PAD_C
  } state_e;

  typedef enum logic [1:0] {
    SEL_PAD,
    SEL_SIGN,
    SEL_TEXT
  } sel_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic size;
    logic emit;
    sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_dec;
    logic conv_last;
    logic minus;
    logic left;
    logic zero;
    logic pad_nz;
    logic pad_one;
    logic txt_nz;
    logic txt_one;
    logic slot_free;
  } dp_sts_t;

endpackage

>>> rtl/iff_req_if.sv
// request channel: one field to format per item
// depends on iff_pkg for the field widths

interface iff_req_if;
  import iff_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   req_type;
  logic [VALUE_W-1:0]  value;
  logic [WIDTH_W-1:0]  width;
  logic                align_left;
  logic                fill_zero;

  modport source (
    output valid, req_type, value, width, align_left, fill_zero,
    input  ready
  );

  modport sink (
    input  valid, req_type, value, width, align_left, fill_zero,
    output ready
  );
endinterface

>>> rtl/iff_chr_if.sv
// character channel: one ascii character per item
// depends on iff_pkg for the field widths

interface iff_chr_if;
  import iff_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (
    output valid, ch, last,
    input  ready
  );

  modport sink (
    input  valid, ch, last,
    output ready
  );
endinterface

>>> rtl/iff_ctrl.sv
// controller of the formatter: sequences load, conversion, sizing and emission
// depends on iff_pkg for the state, command and status types

module iff_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  iff_pkg::dp_sts_t sts_i,
  output iff_pkg::dp_cmd_t cmd_o
);
  import iff_pkg::*;

  state_e state_q, state_d;

  logic   pada_act, sign_act, padb_act, text_act, padc_act;
  state_e after_text, after_padb, after_sign, after_pada, first_phase;

  // each phase is skipped when it has nothing to emit
  assign pada_act = !sts_i.left && !sts_i.zero && sts_i.pad_nz;
  assign sign_act = sts_i.minus;
  assign padb_act = !sts_i.left && sts_i.zero && sts_i.pad_nz;
  assign text_act = sts_i.txt_nz;
  assign padc_act = sts_i.left && sts_i.pad_nz;

  assign after_text  = padc_act ? ST_PAD_C : ST_IDLE;
  assign after_padb  = text_act ? ST_TEXT  : after_text;
  assign after_sign  = padb_act ? ST_PAD_B : after_padb;
  assign after_pada  = sign_act ? ST_SIGN  : after_sign;
  assign first_phase = pada_act ? ST_PAD_A : after_pada;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, conv: 1'b0, size: 1'b0, emit: 1'b0, sel: SEL_PAD};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!sts_i.is_dec) begin
          state_d = ST_SIZE;
        end else begin
          cmd_o.conv = 1'b1;
          if (sts_i.conv_last) state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = ST_ROUTE;
      end
      ST_ROUTE: begin
        state_d = first_phase;
      end
      ST_PAD_A: begin
        cmd_o.sel = SEL_PAD;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pad_one) state_d = after_pada;
        end
      end
      ST_SIGN: begin
        cmd_o.sel = SEL_SIGN;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = after_sign;
        end
      end
      ST_PAD_B: begin
        cmd_o.sel = SEL_PAD;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pad_one) state_d = after_padb;
        end
      end
      ST_TEXT: begin
        cmd_o.sel = SEL_TEXT;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.txt_one) state_d = after_text;
        end
      end
      ST_PAD_C: begin
        cmd_o.sel = SEL_PAD;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pad_one) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/iff_dpath.sv
// datapath of the formatter: request registers, shift-add-3 bcd converter,
// field sizing, character selection and the output register; uses iff_pkg

module iff_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  iff_pkg::dp_cmd_t             cmd_i,
  output iff_pkg::dp_sts_t             sts_o,
  input  logic [iff_pkg::KIND_W-1:0]   req_type_i,
  input  logic [iff_pkg::VALUE_W-1:0]  value_i,
  input  logic [iff_pkg::WIDTH_W-1:0]  width_i,
  input  logic                         align_left_i,
  input  logic                         fill_zero_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [iff_pkg::CH_W-1:0]     ch_o,
  output logic                         last_o
);
  import iff_pkg::*;

  logic [KIND_W-1:0]  kind_q;
  logic [VALUE_W-1:0] val_q;
  logic [WIDTH_W-1:0] width_q;
  logic               left_q, zero_q, minus_q;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [VALUE_W-1:0] bin_q;
  logic [ITER_W-1:0]  iter_q;
  logic [WIDTH_W-1:0] pad_q, remain_q;
  logic [TLEN_W-1:0]  tidx_q;
  logic               out_valid_q, last_q;
  logic [CH_W-1:0]    ch_q;

  logic               is_dec, slot_free;
  logic [15:0]        v16;
  logic [VALUE_W-1:0] mag;
  logic               neg;
  logic [BCD_W-1:0]   adj;
  logic [TLEN_W-1:0]  ndig, tlen, len;
  logic [WIDTH_W-1:0] len_w, pad_d;
  logic [TLEN_W-1:0]  tpos;
  logic [3:0]         nib;
  logic [CH_W-1:0]    base, txt_ch, emit_ch;

  always_comb begin
    case (kind_q)
      KIND_S16, KIND_S32, KIND_U16: is_dec = 1'b1;
      default:                      is_dec = 1'b0;
    endcase
  end

  assign slot_free = !out_valid_q || out_ready_i;

  // magnitude of the operand, most negative values wrap to their own magnitude
  always_comb begin
    v16 = value_i[15:0];
    neg = 1'b0;
    mag = {16'h0, v16};
    case (req_type_i)
      KIND_S16: begin
        neg = v16[15];
        mag = {16'h0, (neg ? 16'(~v16 + 16'd1) : v16)};
      end
      KIND_S32: begin
        neg = value_i[VALUE_W-1];
        mag = neg ? (~value_i + 32'd1) : value_i;
      end
      default: begin
        neg = 1'b0;
        mag = {16'h0, v16};
      end
    endcase
  end

  // one shift-add-3 step: adjust every digit, then shift in the next bit
  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
    end
    bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
  end

  // digit count: position of the highest nonzero digit, at least one
  always_comb begin
    ndig = TLEN_W'(1);
    for (int i = 1; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) ndig = TLEN_W'(i + 1);
    end
  end

  always_comb begin
    case (kind_q)
      KIND_S16, KIND_S32, KIND_U16, KIND_HEXL, KIND_HEXU: tlen = ndig;
      KIND_CHAR: tlen = (val_q[7:0] != 8'h00) ? TLEN_W'(1) : TLEN_W'(0);
      default:   tlen = TLEN_W'(0);
    endcase
    len   = tlen + TLEN_W'(minus_q);
    len_w = WIDTH_W'(len);
    pad_d = (width_q > len_w) ? (width_q - len_w) : '0;
  end

  // text is emitted from the most significant digit down
  assign tpos = tidx_q - TLEN_W'(1);

  always_comb begin
    nib = 4'd0;
    for (int i = 0; i < NDIG; i++) begin
      if (tpos == TLEN_W'(i)) nib = bcd_q[4*i +: 4];
    end
    base = (kind_q == KIND_HEXU) ? CH_UPPER_A : CH_LOWER_A;
    if (kind_q == KIND_CHAR) begin
      txt_ch = val_q[7:0];
    end else if (nib > 4'd9) begin
      txt_ch = base + CH_W'(nib - 4'd10);
    end else begin
      txt_ch = CH_ZERO + CH_W'(nib);
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_PAD:  emit_ch = (zero_q && !left_q) ? CH_ZERO : CH_SPACE;
      SEL_SIGN: emit_ch = CH_MINUS;
      SEL_TEXT: emit_ch = txt_ch;
      default:  emit_ch = CH_SPACE;
    endcase
  end

  // request, converter and counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= req_type_i;
      val_q   <= value_i;
      width_q <= width_i;
      left_q  <= align_left_i;
      zero_q  <= fill_zero_i;
      minus_q <= neg;
      bin_q   <= mag;
      iter_q  <= '0;
      case (req_type_i)
        KIND_S16, KIND_S32, KIND_U16: bcd_q <= '0;
        default:                      bcd_q <= {8'h00, value_i};
      endcase
    end else if (cmd_i.conv) begin
      bcd_q  <= bcd_d;
      bin_q  <= {bin_q[VALUE_W-2:0], 1'b0};
      iter_q <= iter_q + ITER_W'(1);
    end else if (cmd_i.size) begin
      pad_q    <= pad_d;
      tidx_q   <= tlen;
      remain_q <= pad_d + len_w;
    end else if (cmd_i.emit) begin
      remain_q <= remain_q - WIDTH_W'(1);
      if (cmd_i.sel == SEL_PAD)  pad_q  <= pad_q - WIDTH_W'(1);
      if (cmd_i.sel == SEL_TEXT) tidx_q <= tidx_q - TLEN_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ch_q   <= emit_ch;
      last_q <= (remain_q == WIDTH_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign ch_o        = ch_q;
  assign last_o      = last_q;

  assign sts_o.is_dec    = is_dec;
  assign sts_o.conv_last = (iter_q == {ITER_W{1'b1}});
  assign sts_o.minus     = minus_q;
  assign sts_o.left      = left_q;
  assign sts_o.zero      = zero_q;
  assign sts_o.pad_nz    = (pad_q != '0);
  assign sts_o.pad_one   = (pad_q == WIDTH_W'(1));
  assign sts_o.txt_nz    = (tidx_q != '0);
  assign sts_o.txt_one   = (tidx_q == TLEN_W'(1));
  assign sts_o.slot_free = slot_free;

endmodule

>>> rtl/integer_field_formatter.sv
// top level of the integer field formatter: controller plus datapath
// depends on iff_pkg, iff_req_if, iff_chr_if, iff_ctrl and iff_dpath
//
//   channel  dir  payload                                        handshake
//   req_i    in   req_type, value, width, align_left, fill_zero  valid/ready
//   chr_o    out  ch, last (last marks the field's final char)   valid/ready
//
// a field of a decimal kind first passes through the shift-add-3 converter, one
// bit per cycle, before its characters are emitted; the other kinds skip it
// one field is worked on at a time; req_i is ready only between fields
// a stalled consumer holds the output register and pauses emission
// reset clears the state machine and the output valid flag

module integer_field_formatter (
  input  logic      clk_i,
  input  logic      rst_ni,
  iff_req_if.sink   req_i,
  iff_chr_if.source chr_o
);
  import iff_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  iff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iff_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_i.req_type),
    .value_i      (req_i.value),
    .width_i      (req_i.width),
    .align_left_i (req_i.align_left),
    .fill_zero_i  (req_i.fill_zero),
    .out_ready_i  (chr_o.ready),
    .out_valid_o  (chr_o.valid),
    .ch_o         (chr_o.ch),
    .last_o       (chr_o.last)
  );

endmodule
